/* hdl/fsa_pkg.sv */
// ----------------------------------------------------------------------------
// fsa_pkg: shared constants and types for the two-stack word engine
// Word codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package fsa_pkg;

	localparam int DefDataDepth   = 32;
	localparam int DefReturnDepth = 32;
	localparam int DefCellWidth   = 32;

	localparam logic [4:0] OP_LIT    = 5'd0;
	localparam logic [4:0] OP_DROP   = 5'd1;
	localparam logic [4:0] OP_CLRD   = 5'd2;
	localparam logic [4:0] OP_SWAP   = 5'd3;
	localparam logic [4:0] OP_DUP    = 5'd4;
	localparam logic [4:0] OP_OVER   = 5'd5;
	localparam logic [4:0] OP_QDUP   = 5'd6;
	localparam logic [4:0] OP_CLRR   = 5'd7;
	localparam logic [4:0] OP_TOR    = 5'd8;
	localparam logic [4:0] OP_RFETCH = 5'd9;
	localparam logic [4:0] OP_RFROM  = 5'd10;
	localparam logic [4:0] OP_AND    = 5'd11;
	localparam logic [4:0] OP_OR     = 5'd12;
	localparam logic [4:0] OP_XOR    = 5'd13;
	localparam logic [4:0] OP_NOT    = 5'd14;
	localparam logic [4:0] OP_SHIFT  = 5'd15;
	localparam logic [4:0] OP_ADD    = 5'd16;
	localparam logic [4:0] OP_SUB    = 5'd17;
	localparam logic [4:0] OP_NEG    = 5'd18;
	localparam logic [4:0] OP_DIVMOD = 5'd19;
	localparam logic [4:0] OP_DIV    = 5'd20;
	localparam logic [4:0] OP_MOD    = 5'd21;
	localparam logic [4:0] OP_MUL    = 5'd22;
	localparam logic [4:0] OP_ABS    = 5'd23;
	localparam logic [4:0] OP_MAX    = 5'd24;
	localparam logic [4:0] OP_MIN    = 5'd25;
	localparam logic [4:0] OP_EQ     = 5'd26;
	localparam logic [4:0] OP_LT     = 5'd27;
	localparam logic [4:0] OP_GT     = 5'd28;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_EXEC  = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_WR2   = 7'b0010000,
		S_FETCH = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

endpackage

/* hdl/fsa_ram.sv */
// ----------------------------------------------------------------------------
// fsa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fsa_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* hdl/fsa_div.sv */
// ----------------------------------------------------------------------------
// fsa_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsa_div import fsa_pkg::*; #(
	parameter int CellWidth = DefCellWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CellWidth-1:0] dividend,
	input  logic [CellWidth-1:0] divisor,
	output logic                 done,
	output logic [CellWidth-1:0] quotient,
	output logic [CellWidth-1:0] remainder
);

	localparam int CntW = $clog2(CellWidth + 1);

	logic [CntW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CellWidth-1:0] quo_q, rem_q, dvs_q;
	logic [CellWidth:0]   trial;

	assign trial = {rem_q, quo_q[CellWidth-1]} - {1'b0, dvs_q};

	// iterate one bit a cycle; flag done once the last bit has landed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && cnt_q == CntW'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(CellWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[CellWidth]) begin
				rem_q <= trial[CellWidth-1:0];
				quo_q <= {quo_q[CellWidth-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CellWidth-2:0], quo_q[CellWidth-1]};
				quo_q <= {quo_q[CellWidth-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hdl/forth_stack_alu.sv */
// ----------------------------------------------------------------------------
// forth_stack_alu: two-stack word engine
// Executes one stack word per request; reports top cells, depths, status.
// ----------------------------------------------------------------------------
// One request at a time. After a request is taken the engine reads top,
// second and the return top from the registered-read RAMs in its read
// phases, then executes and writes back, fetches the new top two cells in
// its fetch phases and loads the output register. Swap and /mod add a write
// state; /mod, divide and mod also pass through the bit-serial divider. A new
// request is taken only once the response has left. The top cells shown are
// read back from the data RAM, so result 0 for an empty stack is forced by
// the depth.
module forth_stack_alu import fsa_pkg::*; #(
	parameter int DATA_DEPTH   = DefDataDepth,
	parameter int RETURN_DEPTH = DefReturnDepth,
	parameter int CELL_WIDTH   = DefCellWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  op,
	input  logic [31:0] literal_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] top_value,
	output logic [31:0] second_value,
	output logic [5:0]  data_depth,
	output logic [5:0]  return_depth,
	output logic [1:0]  status
);

	localparam int W   = CELL_WIDTH;
	localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
	localparam int RAW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
	localparam int DCW = $clog2(DATA_DEPTH + 1);
	localparam int RCW = $clog2(RETURN_DEPTH + 1);
	localparam int SHW = $clog2(W);

	state_t state_q;
	logic [4:0]   op_q;
	logic [W-1:0] lit_q, a_q, b_q, r_q;
	logic [DCW-1:0] dc_q;
	logic [RCW-1:0] rc_q;
	logic [1:0]   st_q;
	logic         fsel_q;

	// data RAM reads top and second one after the other on its one read port
	logic           d_we;
	logic [DAW-1:0] d_waddr, d_raddr;
	logic [W-1:0]   d_wdata, d_rdata;
	logic           r_we;
	logic [RAW-1:0] r_waddr, r_raddr;
	logic [W-1:0]   r_wdata, r_rdata;

	fsa_ram #(.Width(W), .Depth(DATA_DEPTH)) u_dram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata));
	fsa_ram #(.Width(W), .Depth(RETURN_DEPTH)) u_rram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata));

	logic         div_start, div_done;
	logic [W-1:0] quo, rem;
	fsa_div #(.CellWidth(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(b_q),
		.divisor(a_q), .done(div_done), .quotient(quo), .remainder(rem));

	// read phase counter: 0 top, 1 second, 2 done
	logic [1:0] rph_q;

	logic d1, d2, dfull, rempty, rfull;
	assign d1     = dc_q >= DCW'(1);
	assign d2     = dc_q >= DCW'(2);
	assign dfull  = dc_q >= DCW'(DATA_DEPTH);
	assign rempty = rc_q == '0;
	assign rfull  = rc_q >= RCW'(RETURN_DEPTH);

	function automatic logic slt(input logic [W-1:0] x, input logic [W-1:0] y);
		slt = $signed(x) < $signed(y);
	endfunction

	// shift with direction from the count sign
	logic [W-1:0] mag, shres;
	assign mag = a_q[W-1] ? (~a_q + 1'b1) : a_q;
	always_comb begin
		if (mag >= W'(W)) shres = '0;
		else if (a_q[W-1]) shres = b_q >> mag[SHW-1:0];
		else shres = b_q << mag[SHW-1:0];
	end

	logic [2*W-1:0] prod;
	assign prod = b_q * a_q;

	// execute: status, write, new depths
	logic [1:0]     x_st;
	logic           x_dwe, x_rwe;
	logic [DCW-1:0] x_dc;
	logic [RCW-1:0] x_rc;
	logic [DCW-1:0] x_addr;
	logic [W-1:0]   x_dat;
	logic           x_div, x_swap, x_rpush;
	always_comb begin
		x_st = ST_OK; x_dwe = 1'b0; x_rwe = 1'b0; x_dc = dc_q; x_rc = rc_q;
		x_addr = dc_q - DCW'(2); x_dat = '0; x_div = 1'b0; x_swap = 1'b0;
		x_rpush = 1'b0;
		case (op_q)
			OP_LIT: if (dfull) x_st = ST_OVER;
				else begin x_dwe = 1'b1; x_addr = dc_q; x_dat = lit_q; x_dc = dc_q + 1'b1; end
			OP_DROP: if (!d1) x_st = ST_UNDER; else x_dc = dc_q - 1'b1;
			OP_CLRD: x_dc = '0;
			OP_CLRR: x_rc = '0;
			OP_SWAP: if (!d2) x_st = ST_UNDER;
				else begin x_dwe = 1'b1; x_addr = dc_q - DCW'(1); x_dat = b_q; x_swap = 1'b1; end
			OP_DUP, OP_QDUP: if (!d1) x_st = ST_UNDER;
				else if (op_q == OP_QDUP && a_q == '0) x_st = ST_OK;
				else if (dfull) x_st = ST_OVER;
				else begin x_dwe = 1'b1; x_addr = dc_q; x_dat = a_q; x_dc = dc_q + 1'b1; end
			OP_OVER: if (!d2) x_st = ST_UNDER;
				else if (dfull) x_st = ST_OVER;
				else begin x_dwe = 1'b1; x_addr = dc_q; x_dat = b_q; x_dc = dc_q + 1'b1; end
			OP_TOR: if (!d1) x_st = ST_UNDER;
				else if (rfull) x_st = ST_OVER;
				else begin x_rwe = 1'b1; x_rc = rc_q + 1'b1; x_dc = dc_q - 1'b1; end
			OP_RFETCH, OP_RFROM: if (rempty) x_st = ST_UNDER;
				else if (dfull) x_st = ST_OVER;
				else begin
					x_dwe = 1'b1; x_addr = dc_q; x_dat = r_q; x_dc = dc_q + 1'b1;
					if (op_q == OP_RFROM) x_rc = rc_q - 1'b1;
				end
			OP_NOT, OP_NEG, OP_ABS: if (!d1) x_st = ST_UNDER;
				else begin
					x_dwe = 1'b1; x_addr = dc_q - DCW'(1);
					if (op_q == OP_NOT) x_dat = ~a_q;
					else if (op_q == OP_NEG || a_q[W-1]) x_dat = ~a_q + 1'b1;
					else x_dat = a_q;
				end
			OP_AND, OP_OR, OP_XOR, OP_SHIFT, OP_ADD, OP_SUB, OP_DIVMOD, OP_DIV,
			OP_MOD, OP_MUL, OP_MAX, OP_MIN, OP_EQ, OP_LT, OP_GT:
				if (!d2) x_st = ST_UNDER;
				else if ((op_q == OP_DIVMOD || op_q == OP_DIV || op_q == OP_MOD)
					&& a_q == '0) x_st = ST_DIVZ;
				else if (op_q == OP_DIVMOD || op_q == OP_DIV || op_q == OP_MOD)
					x_div = 1'b1;
				else begin
					x_dwe = 1'b1; x_dc = dc_q - 1'b1;
					case (op_q)
						OP_AND:   x_dat = b_q & a_q;
						OP_OR:    x_dat = b_q | a_q;
						OP_XOR:   x_dat = b_q ^ a_q;
						OP_SHIFT: x_dat = shres;
						OP_ADD:   x_dat = b_q + a_q;
						OP_SUB:   x_dat = b_q - a_q;
						OP_MUL:   x_dat = prod[W-1:0];
						OP_MAX:   x_dat = slt(b_q, a_q) ? a_q : b_q;
						OP_MIN:   x_dat = slt(a_q, b_q) ? a_q : b_q;
						OP_EQ:    x_dat = W'(b_q == a_q);
						OP_LT:    x_dat = W'(slt(b_q, a_q));
						default:  x_dat = W'(slt(a_q, b_q));
					endcase
				end
			default: ;
		endcase
		x_rpush = x_rwe;
	end

	logic [W-1:0] out_top_q, out_sec_q;

	// ram port drive
	always_comb begin
		d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
		r_we = 1'b0; r_waddr = RAW'(rc_q); r_wdata = a_q;
		r_raddr = RAW'(rc_q - RCW'(1));
		div_start = 1'b0;
		case (state_q)
			S_READ: d_raddr = (rph_q == 2'd0) ? DAW'(dc_q - DCW'(1)) : DAW'(dc_q - DCW'(2));
			S_EXEC: begin
				d_we = x_dwe; d_waddr = DAW'(x_addr); d_wdata = x_dat;
				r_we = x_rpush; div_start = x_div;
			end
			S_DIV: if (div_done) begin
				d_we = 1'b1; d_waddr = DAW'(dc_q - DCW'(2));
				d_wdata = (op_q == OP_DIV) ? quo : rem;
			end
			S_WR2: begin
				d_we = 1'b1;
				if (op_q == OP_DIVMOD) begin d_waddr = DAW'(dc_q - DCW'(1)); d_wdata = quo; end
				else begin d_waddr = DAW'(dc_q - DCW'(2)); d_wdata = a_q; end
			end
			S_FETCH: d_raddr = (rph_q == 2'd0) ? DAW'(dc_q - DCW'(1)) : DAW'(dc_q - DCW'(2));
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dc_q    <= '0;
			rc_q    <= '0;
			rph_q   <= '0;
			fsel_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid && !out_valid) begin
					state_q <= S_READ; rph_q <= '0;
				end
				S_READ: begin
					rph_q <= rph_q + 1'b1;
					if (rph_q == 2'd2) state_q <= S_EXEC;
				end
				S_EXEC: begin
					dc_q <= x_dc; rc_q <= x_rc;
					if (x_div) state_q <= S_DIV;
					else if (x_swap) state_q <= S_WR2;
					else begin state_q <= S_FETCH; rph_q <= '0; end
				end
				S_DIV: if (div_done) begin
					if (op_q == OP_DIVMOD) state_q <= S_WR2;
					else begin dc_q <= dc_q - 1'b1; state_q <= S_FETCH; rph_q <= '0; end
				end
				S_WR2: begin state_q <= S_FETCH; rph_q <= '0; end
				S_FETCH: begin
					rph_q <= rph_q + 1'b1;
					if (rph_q == 2'd2) state_q <= S_OUT;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			fsel_q <= 1'b0;
		end
	end

	// capture request, operands and results
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !out_valid) begin
			op_q <= op; lit_q <= W'(literal_value);
		end
		if (state_q == S_READ && rph_q == 2'd1) a_q <= d_rdata;
		if (state_q == S_READ && rph_q == 2'd2) begin b_q <= d_rdata; r_q <= r_rdata; end
		if (state_q == S_EXEC) st_q <= x_st;
		if (state_q == S_FETCH && rph_q == 2'd1) out_top_q <= d_rdata;
		if (state_q == S_FETCH && rph_q == 2'd2) out_sec_q <= d_rdata;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (state_q == S_OUT) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	logic [W-1:0] top_c, sec_c;
	assign top_c = d1 ? out_top_q : '0;
	assign sec_c = d2 ? out_sec_q : '0;

	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			top_value    <= 32'(top_c);
			second_value <= 32'(sec_c);
			data_depth   <= 6'(dc_q);
			return_depth <= 6'(rc_q);
			status       <= st_q;
		end
	end

	assign in_ready = state_q == S_IDLE && !out_valid && !fsel_q;

	// checks
	a_dc_range: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q <= DCW'(DATA_DEPTH)) else $error("data depth past limit");
	a_rc_range: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= RCW'(RETURN_DEPTH)) else $error("return depth past limit");
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("request taken twice");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT)) else $error("stray response");

endmodule
